>>> design/lts_pkg.sv
// ----------------------------------------------------------------------------
// lts_pkg
// shared types, class codes and keyword table for the token scanner
// ----------------------------------------------------------------------------
package lts_pkg;

	localparam int MaxBufferDef    = 4096;
	localparam int KeywordCountDef = 35;
	localparam int KwTable         = 35;
	localparam int PosW            = 12;
	localparam int LenLimit        = 4095;

	localparam logic [5:0] C_END     = 6'd0;
	localparam logic [5:0] C_IDENT   = 6'd36;
	localparam logic [5:0] C_INT     = 6'd37;
	localparam logic [5:0] C_CHARC   = 6'd38;
	localparam logic [5:0] C_LPAR    = 6'd39;
	localparam logic [5:0] C_RPAR    = 6'd40;
	localparam logic [5:0] C_STAR    = 6'd41;
	localparam logic [5:0] C_STARSL  = 6'd42;
	localparam logic [5:0] C_PLUS    = 6'd43;
	localparam logic [5:0] C_COMMA   = 6'd44;
	localparam logic [5:0] C_MINUS   = 6'd45;
	localparam logic [5:0] C_DOT     = 6'd46;
	localparam logic [5:0] C_DOTDOT  = 6'd47;
	localparam logic [5:0] C_SLASH   = 6'd48;
	localparam logic [5:0] C_COMMENT = 6'd49;
	localparam logic [5:0] C_COLON   = 6'd50;
	localparam logic [5:0] C_ASSIGN  = 6'd51;
	localparam logic [5:0] C_SEMI    = 6'd52;
	localparam logic [5:0] C_LT      = 6'd53;
	localparam logic [5:0] C_LE      = 6'd54;
	localparam logic [5:0] C_NE      = 6'd55;
	localparam logic [5:0] C_EQ      = 6'd56;
	localparam logic [5:0] C_GT      = 6'd57;
	localparam logic [5:0] C_GE      = 6'd58;
	localparam logic [5:0] C_LBRK    = 6'd59;
	localparam logic [5:0] C_RBRK    = 6'd60;
	localparam logic [5:0] C_ILLEGAL = 6'd61;

	localparam logic [7:0] CH_QUOTE = 8'd39;
	localparam logic [7:0] CH_STAR  = 8'd42;
	localparam logic [7:0] CH_SLASH = 8'd47;
	localparam logic [7:0] CH_EQ    = 8'd61;
	localparam logic [7:0] CH_GT    = 8'd62;
	localparam logic [7:0] CH_DOT   = 8'd46;

	// scan modes, one-hot
	typedef enum logic [11:0] {
		M_IDLE         = 12'b0000_0000_0001,
		M_IDENT        = 12'b0000_0000_0010,
		M_NUMBER       = 12'b0000_0000_0100,
		M_CHARC        = 12'b0000_0000_1000,
		M_STAR         = 12'b0000_0001_0000,
		M_DOT          = 12'b0000_0010_0000,
		M_SLASH        = 12'b0000_0100_0000,
		M_COLON        = 12'b0000_1000_0000,
		M_LESS         = 12'b0001_0000_0000,
		M_GREATER      = 12'b0010_0000_0000,
		M_COMMENT      = 12'b0100_0000_0000,
		M_COMMENT_STAR = 12'b1000_0000_0000
	} mode_t;

	typedef struct packed {
		logic       valid;
		logic [5:0] cls;
		logic [11:0] start;
		logic [11:0] len;
	} tok_t;

	// keyword text, 10 bytes each, byte 0 first in bits [7:0]; blank past the end, zero from byte 10
	function automatic logic [7:0] kw_char(input int k, input int at);
		logic [79:0] t;
		case (k)
			0:  t = {"       ", "dna"};
			1:  t = {"     ", "yarra"};
			2:  t = {"     ", "nigeb"};
			3:  t = {"      ", "loob"};
			4:  t = {"      ", "llac"};
			5:  t = {"      ", "esac"};
			6:  t = {"      ", "rahc"};
			7:  t = {"  ", "tnatsnoc"};
			8:  t = {"       ", "mid"};
			9:  t = {"        ", "od"};
			10: t = {"      ", "esle"};
			11: t = {"       ", "dne"};
			12: t = {"     ", "eslaf"};
			13: t = {"       ", "rof"};
			14: t = {"        ", "fi"};
			15: t = {"     ", "tupni"};
			16: t = {"   ", "regetni"};
			17: t = {"       ", "ton"};
			18: t = {"        ", "fo"};
			19: t = {"        ", "ro"};
			20: t = {"    ", "tuptuo"};
			21: t = {" ", "erudecorp"};
			22: t = {"   ", "margorp"};
			23: t = {"      ", "daer"};
			24: t = {"      ", "laer"};
			25: t = {"    ", "taeper"};
			26: t = {"       ", "tes"};
			27: t = {"      ", "pots"};
			28: t = {"      ", "neht"};
			29: t = {"        ", "ot"};
			30: t = {"      ", "eurt"};
			31: t = {"     ", "litnu"};
			32: t = {"       ", "rav"};
			33: t = {"     ", "elihw"};
			default: t = {"     ", "etirw"};
		endcase
		if (at >= 10) return 8'd0;
		return t[at*8 +: 8];
	endfunction

	function automatic logic [3:0] kw_len(input int k);
		logic [3:0] l;
		case (k)
			0, 8, 11, 13, 17, 26, 32:                 l = 4'd3;
			9, 14, 18, 19, 29:                        l = 4'd2;
			3, 4, 5, 6, 10, 23, 24, 27, 28, 30:       l = 4'd4;
			7:                                        l = 4'd8;
			16, 22:                                   l = 4'd7;
			20, 25:                                   l = 4'd6;
			21:                                       l = 4'd9;
			default:                                  l = 4'd5;
		endcase
		return l;
	endfunction

endpackage

>>> design/lexical_token_scanner.sv
// ----------------------------------------------------------------------------
// lexical_token_scanner
// character-at-a-time tokenizer with incremental keyword matching
// ----------------------------------------------------------------------------
//  channel | signals                                   | role
//  in      | in_valid, in_ready, req_type, char_code   | one byte or end mark
//  out     | out_valid, out_ready, token_class,        | tokens, up to two
//          | token_start, token_length, last_of_run    | per input item
//
// one item per cycle while in_ready is high; its tokens register when taken
// an item yielding two tokens holds the input until the first is taken
// in_ready is high while the result queue can empty before the next edge
// reset returns the scanner to idle with positions at zero
// an end item flushes any open token, emits class 0 and restarts positions
module lexical_token_scanner import lts_pkg::*; #(
	parameter int MAX_BUFFER    = MaxBufferDef,
	parameter int KEYWORD_COUNT = KeywordCountDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  char_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  token_class,
	output logic [11:0] token_start,
	output logic [11:0] token_length,
	output logic        last_of_run
);
	localparam int PosLimitI = ((MAX_BUFFER - 1) < 4095) ? (MAX_BUFFER - 1) : 4095;
	localparam logic [11:0] PosLimit = 12'(PosLimitI);
	localparam logic [11:0] LenLim   = 12'(LenLimit);

	mode_t mode_q, mode_d;
	logic [11:0] begin_q, begin_d, count_q, count_d, pos_q, pos_d;
	logic [KEYWORD_COUNT-1:0] cand_q, cand_d, cand_next, cand_first;
	logic bad_q, bad_d;
	logic [5:0] kw_class;
	tok_t tok_a, tok_b;
	logic busy, take;

	assign in_ready = !busy;
	assign take     = in_valid && !busy;

	lts_kw_match #(.KW(KEYWORD_COUNT)) u_kw (
		.cand(cand_q), .ch(char_code), .at(count_q), .count(count_q),
		.cand_next(cand_next), .cand_first(cand_first), .kw_class(kw_class)
	);

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
	endfunction
	function automatic logic is_num(input logic [7:0] c);
		return c >= 8'd48 && c <= 8'd57;
	endfunction

	logic [11:0] cnt_inc;
	logic [5:0]  pend_cls;
	logic        absorbed;
	assign cnt_inc = (count_q < LenLim) ? count_q + 12'd1 : LenLim;

	// class of the open token if it is closed now
	always_comb begin
		case (mode_q)
			M_IDENT:   pend_cls = kw_class;
			M_NUMBER:  pend_cls = bad_q ? C_ILLEGAL : C_INT;
			M_STAR:    pend_cls = C_STAR;
			M_DOT:     pend_cls = C_DOT;
			M_SLASH:   pend_cls = C_SLASH;
			M_COLON:   pend_cls = C_COLON;
			M_LESS:    pend_cls = C_LT;
			M_GREATER: pend_cls = C_GT;
			default:   pend_cls = C_ILLEGAL;
		endcase
	end

	always_comb begin
		logic [5:0] pair;
		logic [5:0] single;
		mode_d   = mode_q;
		begin_d  = begin_q;
		count_d  = count_q;
		pos_d    = pos_q;
		cand_d   = cand_q;
		bad_d    = bad_q;
		tok_a    = '0;
		tok_b    = '0;
		absorbed = 1'b0;
		pair     = 6'd0;
		single   = C_ILLEGAL;
		if (req_type) begin
			// end of buffer: flush, end mark, back to reset
			if (mode_q != M_IDLE)
				tok_a = '{1'b1, pend_cls, begin_q, count_q};
			tok_b   = '{1'b1, C_END, pos_q, 12'd0};
			mode_d  = M_IDLE;
			begin_d = '0;
			count_d = '0;
			pos_d   = '0;
			cand_d  = '0;
			bad_d   = 1'b0;
		end else begin
			pos_d = (pos_q < PosLimit) ? pos_q + 12'd1 : PosLimit;
			case (mode_q)
				M_IDLE: absorbed = 1'b0;
				M_IDENT: begin
					if (is_letter(char_code) || is_num(char_code)) begin
						absorbed = 1'b1;
						cand_d   = cand_next;
						count_d  = cnt_inc;
					end
				end
				M_NUMBER: begin
					if (is_letter(char_code) || is_num(char_code)) begin
						absorbed = 1'b1;
						if (is_letter(char_code)) bad_d = 1'b1;
						count_d = cnt_inc;
					end
				end
				M_CHARC: begin
					absorbed = 1'b1;
					count_d  = cnt_inc;
					if (char_code == CH_QUOTE) begin
						tok_a  = '{1'b1, C_CHARC, begin_q, cnt_inc};
						mode_d = M_IDLE;
					end
				end
				M_COMMENT, M_COMMENT_STAR: begin
					absorbed = 1'b1;
					count_d  = cnt_inc;
					if (mode_q == M_COMMENT_STAR && char_code == CH_SLASH) begin
						tok_a  = '{1'b1, C_COMMENT, begin_q, cnt_inc};
						mode_d = M_IDLE;
					end else begin
						mode_d = (char_code == CH_STAR) ? M_COMMENT_STAR : M_COMMENT;
					end
				end
				default: begin
					if (mode_q == M_SLASH && char_code == CH_STAR) begin
						absorbed = 1'b1;
						mode_d   = M_COMMENT;
						count_d  = 12'd2;
					end else begin
						if (mode_q == M_STAR && char_code == CH_SLASH) pair = C_STARSL;
						else if (mode_q == M_DOT && char_code == CH_DOT) pair = C_DOTDOT;
						else if (mode_q == M_COLON && char_code == CH_EQ) pair = C_ASSIGN;
						else if (mode_q == M_LESS && char_code == CH_EQ) pair = C_LE;
						else if (mode_q == M_LESS && char_code == CH_GT) pair = C_NE;
						else if (mode_q == M_GREATER && char_code == CH_EQ) pair = C_GE;
						if (pair != 6'd0) begin
							absorbed = 1'b1;
							count_d  = 12'd2;
							tok_a    = '{1'b1, pair, begin_q, 12'd2};
							mode_d   = M_IDLE;
						end
					end
				end
			endcase
			// close the open token that this byte cannot continue
			if (!absorbed && mode_q != M_IDLE) begin
				tok_a  = '{1'b1, pend_cls, begin_q, count_q};
				mode_d = M_IDLE;
			end
			// start a new token with this byte
			if (!absorbed && char_code != 8'd32 && char_code != 8'd9) begin
				begin_d = pos_q;
				count_d = 12'd1;
				if (is_letter(char_code)) begin
					mode_d = M_IDENT;
					cand_d = cand_first;
				end else if (is_num(char_code)) begin
					mode_d = M_NUMBER;
					bad_d  = 1'b0;
				end else begin
					case (char_code)
						CH_QUOTE: mode_d = M_CHARC;
						CH_STAR:  mode_d = M_STAR;
						CH_DOT:   mode_d = M_DOT;
						CH_SLASH: mode_d = M_SLASH;
						8'd58:    mode_d = M_COLON;
						8'd60:    mode_d = M_LESS;
						CH_GT:    mode_d = M_GREATER;
						8'd40:    single = C_LPAR;
						8'd41:    single = C_RPAR;
						8'd43:    single = C_PLUS;
						8'd44:    single = C_COMMA;
						8'd45:    single = C_MINUS;
						8'd59:    single = C_SEMI;
						CH_EQ:    single = C_EQ;
						8'd91:    single = C_LBRK;
						8'd93:    single = C_RBRK;
						default:  single = C_ILLEGAL;
					endcase
					if (mode_d == M_IDLE)
						tok_b = '{1'b1, single, pos_q, 12'd1};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			begin_q <= '0;
			count_q <= '0;
			pos_q   <= '0;
			cand_q  <= '0;
			bad_q   <= 1'b0;
		end else if (take) begin
			mode_q  <= mode_d;
			begin_q <= begin_d;
			count_q <= count_d;
			pos_q   <= pos_d;
			cand_q  <= cand_d;
			bad_q   <= bad_d;
		end
	end

	lts_out_queue u_q (
		.clk(clk), .arst_n(arst_n), .load(take), .tok_a(tok_a), .tok_b(tok_b),
		.busy(busy), .out_valid(out_valid), .out_ready(out_ready),
		.token_class(token_class), .token_start(token_start),
		.token_length(token_length), .last_of_run(last_of_run)
	);
endmodule

>>> design/lts_kw_match.sv
// ----------------------------------------------------------------------------
// lts_kw_match
// per-keyword candidate narrowing and exact-length match lookup
// ----------------------------------------------------------------------------
module lts_kw_match import lts_pkg::*; #(
	parameter int KW = KeywordCountDef
) (
	input  logic [KW-1:0] cand,
	input  logic [7:0]    ch,
	input  logic [11:0]   at,
	input  logic [11:0]   count,
	output logic [KW-1:0] cand_next,
	output logic [KW-1:0] cand_first,
	output logic [5:0]    kw_class
);
	localparam int Used = (KW < KwTable) ? KW : KwTable;

	always_comb begin
		cand_next  = '0;
		cand_first = '0;
		for (int i = 0; i < Used; i++) begin
			cand_first[i] = (kw_char(i, 0) == ch);
			cand_next[i]  = cand[i] && (at < 12'(kw_len(i))) &&
				(kw_char(i, int'(at[3:0])) == ch);
		end
	end

	// lowest matching keyword of exact length wins
	always_comb begin
		kw_class = C_IDENT;
		for (int i = Used - 1; i >= 0; i--) begin
			if (cand[i] && count == 12'(kw_len(i)))
				kw_class = 6'(i + 1);
		end
	end
endmodule

>>> design/lts_out_queue.sv
// ----------------------------------------------------------------------------
// lts_out_queue
// two-entry result buffer that drains one token per cycle while out_ready is high
// ----------------------------------------------------------------------------
module lts_out_queue import lts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  tok_t        tok_a,
	input  tok_t        tok_b,
	output logic        busy,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  token_class,
	output logic [11:0] token_start,
	output logic [11:0] token_length,
	output logic        last_of_run
);
	tok_t e0_q, e1_q;
	logic v0_q, v1_q;

	assign out_valid    = v0_q;
	assign token_class  = e0_q.cls;
	assign token_start  = e0_q.start;
	assign token_length = e0_q.len;
	assign last_of_run  = !v1_q;
	// accept a new item when the queue is empty or empties this cycle
	assign busy = v1_q || (v0_q && !out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else if (load) begin
			if (tok_a.valid) begin
				v0_q <= 1'b1;
				v1_q <= tok_b.valid;
			end else begin
				v0_q <= tok_b.valid;
				v1_q <= 1'b0;
			end
		end else if (v0_q && out_ready) begin
			v0_q <= v1_q;
			v1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			e0_q <= tok_a.valid ? tok_a : tok_b;
			e1_q <= tok_b;
		end else if (v0_q && out_ready) begin
			e0_q <= e1_q;
		end
	end
endmodule

>>> sim/lts_checker.sv
// ----------------------------------------------------------------------------
// lts_checker
// watches both channels of the token scanner, predicts tokens, compares them
// ----------------------------------------------------------------------------
module lts_checker import lts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  char_code,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [5:0]  token_class,
	input  logic [11:0] token_start,
	input  logic [11:0] token_length,
	input  logic        last_of_run,
	output int          fail_count,
	output int          pending_tokens,
	output int          token_total
);

	typedef struct packed {
		logic [5:0]  cls;
		logic [11:0] start;
		logic [11:0] len;
		logic        last;
	} token_t;

	token_t      expected_tokens[$];
	mode_t       mode;
	logic [11:0] tok_begin, tok_len, pos;
	logic [34:0] cands;
	logic        num_bad;
	token_t      step_toks[$];

	function automatic logic is_letter(logic [7:0] c);
		return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
	endfunction

	function automatic logic is_numeral(logic [7:0] c);
		return c >= 8'd48 && c <= 8'd57;
	endfunction

	function automatic logic [11:0] sat(logic [11:0] v);
		return (v == 12'd4095) ? v : v + 12'd1;
	endfunction

	task automatic emit_token(logic [5:0] cls, logic [11:0] st, logic [11:0] ln);
		token_t t;
		t.cls = cls; t.start = st; t.len = ln; t.last = 1'b0;
		if (step_toks.size() < 2) step_toks.push_back(t);
	endtask

	task automatic narrow(logic [7:0] c, logic [11:0] at);
		for (int k = 0; k < KwTable; k++)
			if (cands[k] && (at >= kw_len(k) || kw_char(k, at) != c)) cands[k] = 1'b0;
	endtask

	function automatic logic [5:0] open_class();
		case (mode)
			M_IDENT: begin
				for (int k = 0; k < KwTable; k++)
					if (cands[k] && kw_len(k) == tok_len) return 6'(k + 1);
				return C_IDENT;
			end
			M_NUMBER:  return num_bad ? C_ILLEGAL : C_INT;
			M_STAR:    return C_STAR;
			M_DOT:     return C_DOT;
			M_SLASH:   return C_SLASH;
			M_COLON:   return C_COLON;
			M_LESS:    return C_LT;
			M_GREATER: return C_GT;
			default:   return C_ILLEGAL;
		endcase
	endfunction

	task automatic close_open(logic [5:0] cls);
		emit_token(cls, tok_begin, tok_len);
		mode = M_IDLE;
	endtask

	// true when the byte extends the open token
	task automatic extend_open(logic [7:0] c, output logic taken);
		logic [5:0] pair;
		taken = 1'b1;
		pair = C_END;
		case (mode)
			M_IDLE: taken = 1'b0;
			M_IDENT:
				if (!is_letter(c) && !is_numeral(c)) begin
					close_open(open_class()); taken = 1'b0;
				end else begin
					narrow(c, tok_len); tok_len = sat(tok_len);
				end
			M_NUMBER:
				if (is_letter(c)) begin
					num_bad = 1'b1; tok_len = sat(tok_len);
				end else if (is_numeral(c)) begin
					tok_len = sat(tok_len);
				end else begin
					close_open(open_class()); taken = 1'b0;
				end
			M_CHARC: begin
				tok_len = sat(tok_len);
				if (c == CH_QUOTE) close_open(C_CHARC);
			end
			M_COMMENT, M_COMMENT_STAR: begin
				tok_len = sat(tok_len);
				if (mode == M_COMMENT_STAR && c == CH_SLASH) close_open(C_COMMENT);
				else mode = (c == CH_STAR) ? M_COMMENT_STAR : M_COMMENT;
			end
			default: begin
				if (mode == M_SLASH && c == CH_STAR) begin
					mode = M_COMMENT; tok_len = 12'd2;
				end else begin
					if (mode == M_STAR && c == CH_SLASH) pair = C_STARSL;
					else if (mode == M_DOT && c == CH_DOT) pair = C_DOTDOT;
					else if (mode == M_COLON && c == CH_EQ) pair = C_ASSIGN;
					else if (mode == M_LESS && c == CH_EQ) pair = C_LE;
					else if (mode == M_LESS && c == CH_GT) pair = C_NE;
					else if (mode == M_GREATER && c == CH_EQ) pair = C_GE;
					if (pair != C_END) begin
						tok_len = 12'd2; close_open(pair);
					end else begin
						close_open(open_class()); taken = 1'b0;
					end
				end
			end
		endcase
	endtask

	task automatic begin_token(logic [7:0] c);
		logic [5:0] single;
		if (c == " " || c == 8'd9) return;
		tok_begin = pos;
		tok_len = 12'd1;
		if (is_letter(c)) begin
			mode = M_IDENT; cands = '1; narrow(c, 12'd0); return;
		end
		if (is_numeral(c)) begin
			mode = M_NUMBER; num_bad = 1'b0; return;
		end
		case (c)
			CH_QUOTE: begin mode = M_CHARC; return; end
			CH_STAR:  begin mode = M_STAR; return; end
			CH_DOT:   begin mode = M_DOT; return; end
			CH_SLASH: begin mode = M_SLASH; return; end
			":":      begin mode = M_COLON; return; end
			"<":      begin mode = M_LESS; return; end
			CH_GT:    begin mode = M_GREATER; return; end
			"(":      single = C_LPAR;
			")":      single = C_RPAR;
			"+":      single = C_PLUS;
			",":      single = C_COMMA;
			"-":      single = C_MINUS;
			";":      single = C_SEMI;
			CH_EQ:    single = C_EQ;
			"[":      single = C_LBRK;
			"]":      single = C_RBRK;
			default:  single = C_ILLEGAL;
		endcase
		emit_token(single, pos, 12'd1);
	endtask

	task automatic clear_scan();
		mode = M_IDLE; tok_begin = '0; tok_len = '0; pos = '0; cands = '0; num_bad = 1'b0;
	endtask

	task automatic predict_tokens(logic is_end, logic [7:0] c);
		logic taken;
		step_toks.delete();
		if (is_end) begin
			if (mode != M_IDLE) close_open(open_class());
			emit_token(C_END, pos, 12'd0);
			clear_scan();
		end else begin
			extend_open(c, taken);
			if (!taken) begin_token(c);
			pos = sat(pos);
		end
		if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
		foreach (step_toks[i]) expected_tokens.push_back(step_toks[i]);
	endtask

	always @(posedge clk) begin
		token_t want;
		if (!arst_n) begin
			fail_count = 0;
			token_total = 0;
			expected_tokens.delete();
			clear_scan();
		end else begin
			if (out_valid && out_ready) begin
				token_total++;
				if (expected_tokens.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected token cls=%0d start=%0d len=%0d", token_class,
							token_start, token_length);
				end else begin
					want = expected_tokens.pop_front();
					if (want.cls !== token_class || want.start !== token_start ||
							want.len !== token_length || want.last !== last_of_run) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: exp cls=%0d st=%0d len=%0d last=%0d, got %0d %0d %0d %0d",
								want.cls, want.start, want.len, want.last,
								token_class, token_start, token_length, last_of_run);
					end
				end
			end
			if (in_valid && in_ready) predict_tokens(req_type, char_code);
		end
		pending_tokens = expected_tokens.size();
	end

endmodule

>>> sim/lexical_token_scanner_tb.sv
// ----------------------------------------------------------------------------
// lexical_token_scanner_tb
// drives source text, keywords, operators, comments and noise into the
// scanner with random gaps and back-pressure; the checker predicts each token
// ----------------------------------------------------------------------------
module lexical_token_scanner_tb;
	import lts_pkg::*;

	localparam int WatchLimit = 20000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        req_type;
	logic [7:0]  char_code;
	logic        out_valid;
	logic        out_ready;
	logic [5:0]  token_class;
	logic [11:0] token_start;
	logic [11:0] token_length;
	logic        last_of_run;
	int          fail_count;
	int          pending_tokens;
	int          token_total;
	int          items_sent;
	int          idle_cycles = 0;

	lexical_token_scanner uut (.*);

	lts_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// sample pieces of source text
	string snippets[] = '{
		"begin x := 12; end", "if a<=b then c<>d", "array[1..9] of integer",
		"/* note ** here */", "'q'", "procedure program", "write(read)", "3abc 42 7",
		"while not false do", "constant character", "x>=y>z<w", "a.b .. c",
		"*/ * / ", "repeat until true", "or output and", "var dim set stop"
	};

	// short gap, mostly zero, sometimes long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// valid stays high across back-to-back items and drops only for a gap
	task automatic send_item(logic is_end, logic [7:0] c);
		int g;
		g = gap_len();
		if (items_sent > 1200 && items_sent < 1400) g = 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= is_end;
		char_code <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	// release the input after the last accepted item
	task automatic stop_sending();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
	endtask

	task automatic send_keyword_or_ident();
		int k;
		int n;
		k = $urandom_range(0, KwTable - 1);
		n = int'(kw_len(k));
		if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
		for (int i = 0; i < n; i++) send_item(1'b0, kw_char(k, i));
		if ($urandom_range(0, 3) == 0) send_item(1'b0, 8'($urandom_range(97, 122)));
	endtask

	// receiver: random stalls plus one long hold-off
	initial begin
		logic held;
		held = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && items_sent >= 300) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (60) @(posedge clk);
			end
			out_ready <= ($urandom_range(0, 99) < 70) || (items_sent > 1700);
			@(posedge clk);
		end
	end

	// watchdog on cycles without any accepted item or delivered token
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WatchLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int r;
		logic paused;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = 1'b0;
		char_code = 8'd0;
		items_sent = 0;
		paused = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: operators, pairs, numbers, constants, comments, illegal
		send_text("(),+-;=[]:=<=<>>=..*/");
		send_item(1'b0, 8'd0);
		send_item(1'b0, 8'd255);
		send_item(1'b0, 8'd10);
		send_text("12ab '/*x*/");
		send_item(1'b1, 8'd0);
		send_text("'ab");
		send_item(1'b1, 8'd0);
		send_text("/*a");
		send_item(1'b1, 8'd0);
		send_item(1'b1, 8'd0);

		// random mix: text with structure, mixed with noise
		while (items_sent < 1800) begin
			r = $urandom_range(0, 99);
			if (r < 30) send_text(snippets[$urandom_range(0, snippets.size() - 1)]);
			else if (r < 55) send_keyword_or_ident();
			else if (r < 70) send_item(1'b0, " ");
			else if (r < 88) send_item(1'b0, 8'($urandom_range(0, 127)));
			else if (r < 96) send_item(1'b0, 8'($urandom));
			else send_item(1'b1, 8'($urandom));
			if (!paused && items_sent > 900) begin
				// sender pause until the output side drains
				paused = 1'b1;
				stop_sending();
				while (pending_tokens != 0) @(posedge clk);
			end
		end

		// one long identifier
		for (int i = 0; i < 80; i++) send_item(1'b0, "z");
		send_text("9 ");
		send_item(1'b1, 8'd0);
		stop_sending();

		while (pending_tokens != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("sent %0d items, checked %0d tokens: keywords, operators, comments, end marks",
			items_sent, token_total);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> sim.f
design/lts_pkg.sv
design/lts_kw_match.sv
design/lts_out_queue.sv
design/lexical_token_scanner.sv
sim/lts_checker.sv
sim/lexical_token_scanner_tb.sv
